// ===== hdl/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, function codes and the crc step shared by the request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

	// item kind on the input channel
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_DATA   = 1'b1;

	// supported function codes
	localparam logic [7:0] FC_READ_COILS      = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
	localparam logic [7:0] FC_READ_INPUT      = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
	localparam logic [7:0] FC_WRITE_REG       = 8'd6;
	localparam logic [7:0] FC_READ_EXC_STATUS = 8'd7;
	localparam logic [7:0] FC_COMM_EVENT_CNT  = 8'd11;
	localparam logic [7:0] FC_COMM_EVENT_LOG  = 8'd12;
	localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS      = 8'd16;
	localparam logic [7:0] FC_REPORT_ID       = 8'd17;
	localparam logic [7:0] FC_RW_REGS         = 8'd23;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  BYTE_ZERO = 8'h00;

	// unit id plus up to ten pdu bytes
	localparam int PDU_BYTES = 11;
	localparam int MBAP_BYTES = 6;
	localparam logic [3:0] MBAP_LAST = 4'(MBAP_BYTES - 1);
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		JOB_HDR,
		JOB_DATA,
		JOB_ERR
	} job_kind_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_MBAP,
		PH_PDU,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	// one classified item, handed from the front end to the byte sequencer
	typedef struct packed {
		job_kind_t                       kind;
		logic                            tcp;     // mode seen when the item came in
		logic                            fin;     // this job closes the frame
		logic                            clr;     // error job that restarts the crc
		logic [3:0]                      nbytes;  // bytes held in pdu
		logic [PDU_BYTES-1:0][7:0]       pdu;
		logic [15:0]                     tid;
		logic [8:0]                      len;     // mbap length field
	} mrf_job_t;

	// one byte through the reflected crc-16/modbus
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

// ===== hdl/mrf_front.sv =====
// ----------------------------------------------------------------------------
// mrf_front
// Classifies incoming beats into jobs and tracks the payload still expected.
// ----------------------------------------------------------------------------
module mrf_front import mrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tcp_mode,
	input  logic        accept,
	input  logic        command,
	input  logic [7:0]  function_code,
	input  logic [15:0] start_address,
	input  logic [15:0] quantity,
	input  logic [15:0] write_start_address,
	input  logic [15:0] write_quantity,
	input  logic [7:0]  payload_len,
	input  logic [15:0] single_value,
	input  logic [7:0]  unit_id,
	input  logic [15:0] transaction_id,
	input  logic [7:0]  data_byte,
	output mrf_job_t    job
);

	logic [7:0] remaining_q;
	logic [7:0] remaining_d;
	logic       hdr_ok;
	logic       payload;
	logic [3:0] hlen;

	always_comb begin
		job         = '0;
		job.tcp     = tcp_mode;
		job.tid     = transaction_id;
		hdr_ok      = 1'b1;
		payload     = 1'b0;
		hlen        = 4'd0;
		remaining_d = remaining_q;

		job.pdu[0] = unit_id;
		job.pdu[1] = function_code;
		job.pdu[2] = start_address[15:8];
		job.pdu[3] = start_address[7:0];
		job.pdu[4] = quantity[15:8];
		job.pdu[5] = quantity[7:0];

		unique case (function_code) inside
			FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
				hlen = 4'd5;
			end
			FC_WRITE_COIL, FC_WRITE_REG: begin
				job.pdu[4] = single_value[15:8];
				job.pdu[5] = single_value[7:0];
				hlen = 4'd5;
			end
			FC_WRITE_COILS, FC_WRITE_REGS: begin
				job.pdu[6] = payload_len;
				hlen = 4'd6;
				payload = 1'b1;
			end
			FC_RW_REGS: begin
				job.pdu[6]  = write_start_address[15:8];
				job.pdu[7]  = write_start_address[7:0];
				job.pdu[8]  = write_quantity[15:8];
				job.pdu[9]  = write_quantity[7:0];
				job.pdu[10] = payload_len;
				hlen = 4'd10;
				payload = 1'b1;
			end
			FC_READ_EXC_STATUS, FC_COMM_EVENT_CNT, FC_COMM_EVENT_LOG, FC_REPORT_ID: begin
				hlen = 4'd1;
			end
			default: begin
				hdr_ok = 1'b0;
			end
		endcase

		job.nbytes = hlen + 4'd1;
		job.len    = {5'b0, hlen} + (payload ? {1'b0, payload_len} : 9'd0) + 9'd1;

		if (command == CMD_DATA) begin
			job.nbytes = 4'd1;
			job.pdu[0] = data_byte;
			if (remaining_q == 8'd0) begin
				// stray data beat: error, state untouched
				job.kind = JOB_ERR;
			end else begin
				job.kind    = JOB_DATA;
				job.fin     = (remaining_q == 8'd1);
				remaining_d = remaining_q - 8'd1;
			end
		end else begin
			if (hdr_ok) begin
				job.kind    = JOB_HDR;
				job.fin     = !payload || (payload_len == 8'd0);
				remaining_d = payload ? payload_len : 8'd0;
			end else begin
				job.kind    = JOB_ERR;
				job.clr     = 1'b1;
				remaining_d = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			remaining_q <= 8'd0;
		else if (accept)
			remaining_q <= remaining_d;
	end

endmodule

// ===== hdl/mrf_queue.sv =====
// ----------------------------------------------------------------------------
// mrf_queue
// Short job queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module mrf_queue import mrf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  mrf_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output mrf_job_t head_job
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	mrf_job_t           entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/mrf_back.sv =====
// ----------------------------------------------------------------------------
// mrf_back
// Byte sequencer: walks the head job byte by byte, keeps the running crc.
// ----------------------------------------------------------------------------
module mrf_back import mrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  mrf_job_t    job,
	output logic        pop,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  frame_byte,
	output logic        last,
	output logic        error
);

	phase_t      phase_q, phase_d, cur_phase;
	logic [3:0]  idx_q, idx_d, cur_idx;
	logic [15:0] crc_q, crc_d, crc_base;
	logic        out_valid_q;
	logic [7:0]  byte_q, byte_d;
	logic        last_q, last_d;
	logic        err_q, err_d;
	logic        fire, done;

	always_comb begin
		fire      = head_valid && (!out_valid_q || out_ready);
		cur_phase = phase_q;
		cur_idx   = idx_q;
		if (phase_q == PH_START) begin
			cur_phase = (job.kind == JOB_HDR && job.tcp) ? PH_MBAP : PH_PDU;
			cur_idx   = 4'd0;
		end

		byte_d   = BYTE_ZERO;
		last_d   = 1'b0;
		err_d    = 1'b0;
		done     = 1'b0;
		phase_d  = cur_phase;
		idx_d    = cur_idx;
		crc_d    = crc_q;
		crc_base = crc_q;

		if (job.kind == JOB_ERR) begin
			err_d  = 1'b1;
			last_d = 1'b1;
			done   = 1'b1;
			if (job.clr)
				crc_d = CRC_INIT;
		end else begin
			unique case (cur_phase)
				PH_MBAP: begin
					case (cur_idx)
						4'd0:    byte_d = job.tid[15:8];
						4'd1:    byte_d = job.tid[7:0];
						4'd4:    byte_d = {7'b0, job.len[8]};
						4'd5:    byte_d = job.len[7:0];
						default: byte_d = BYTE_ZERO;
					endcase
					if (cur_idx == MBAP_LAST) begin
						phase_d = PH_PDU;
						idx_d   = 4'd0;
					end else begin
						idx_d = cur_idx + 4'd1;
					end
				end
				PH_PDU: begin
					byte_d = job.pdu[cur_idx];
					// a header restarts the crc at its unit id
					if (job.kind == JOB_HDR && cur_idx == 4'd0)
						crc_base = CRC_INIT;
					crc_d = job.tcp ? crc_base : crc_add(crc_base, byte_d);
					if (cur_idx == job.nbytes - 4'd1) begin
						if (job.fin && !job.tcp) begin
							phase_d = PH_CRC_LO;
						end else begin
							done   = 1'b1;
							last_d = job.fin;
						end
					end else begin
						idx_d = cur_idx + 4'd1;
					end
				end
				PH_CRC_LO: begin
					byte_d  = crc_q[7:0];
					phase_d = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					byte_d = crc_q[15:8];
					last_d = 1'b1;
					done   = 1'b1;
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end

		if (done) begin
			phase_d = PH_START;
			idx_d   = 4'd0;
		end
		pop = fire && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			idx_q       <= 4'd0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			idx_q       <= idx_d;
			crc_q       <= crc_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= byte_d;
			last_q <= last_d;
			err_q  <= err_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last       = last_q;
	assign error      = err_q;

endmodule

// ===== hdl/modbus_request_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_request_framer
// Modbus request frame builder, rtu with crc-16 or tcp with mbap header.
// ----------------------------------------------------------------------------
// A header beat names a request and the block streams its frame bytes out,
// one byte per cycle unless stalled: in rtu mode unit id, pdu and crc low
// byte first; in tcp mode the six mbap bytes, unit id and pdu. Codes 15,
// 16 and 23 then take payload_len data beats, each giving one payload byte,
// and the frame closes after the last one. Input beats are accepted every
// cycle while the two-entry job queue has room, so data beats stream at one
// per cycle; the output side produces one byte per cycle from a single byte
// sequencer unless out_ready stalls it, so a header gives 4 to 17 bytes
// (function-code-only requests in rtu mode up to read/write-multiple in tcp
// mode), a data beat one byte, or three when it closes an rtu frame and the
// crc follows. Unsupported codes and stray data beats give one byte 0 with
// last and error set. tcp_mode is sampled as each beat enters; the user is
// to see it is written only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module modbus_request_framer import mrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// request beats
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  function_code,
	input  logic [15:0] start_address,
	input  logic [15:0] quantity,
	input  logic [15:0] write_start_address,
	input  logic [15:0] write_quantity,
	input  logic [7:0]  payload_len,
	input  logic [15:0] single_value,
	input  logic [7:0]  unit_id,
	input  logic [15:0] transaction_id,
	input  logic [7:0]  data_byte,
	// frame bytes
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last,
	output logic        error
);

	logic     tcp_mode_q;
	logic     in_fire;
	logic     q_full;
	logic     q_valid;
	logic     q_pop;
	mrf_job_t front_job;
	mrf_job_t head_job;

	// mode register, 0 rtu, 1 tcp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tcp_mode_q <= 1'b0;
		else if (cfg_we)
			tcp_mode_q <= cfg_wdata;
	end

	// accept whenever the queue can take the job
	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;

	// front end: decode and payload bookkeeping
	mrf_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.tcp_mode            (tcp_mode_q),
		.accept              (in_fire),
		.command             (command),
		.function_code       (function_code),
		.start_address       (start_address),
		.quantity            (quantity),
		.write_start_address (write_start_address),
		.write_quantity      (write_quantity),
		.payload_len         (payload_len),
		.single_value        (single_value),
		.unit_id             (unit_id),
		.transaction_id      (transaction_id),
		.data_byte           (data_byte),
		.job                 (front_job)
	);

	// decouples input acceptance from byte emission
	mrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_fire),
		.push_job   (front_job),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_job   (head_job)
	);

	// back end: byte sequencer with crc and registered output
	mrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.job        (head_job),
		.pop        (q_pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.frame_byte (frame_byte),
		.last       (last),
		.error      (error)
	);

	// an error beat is always a lone, closing zero byte
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && (frame_byte == BYTE_ZERO))
		else $error("error beat without last or with nonzero byte");

	// an accepted beat leaves at least one job queued
	a_push_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> q_valid)
		else $error("job lost after acceptance");

	// the sequencer never retires a job that is not there, nor while its output stalls
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && (!out_valid || out_ready))
		else $error("pop without a job or while output stalled");

endmodule

// ===== verif/modbus_request_framer_test.sv =====
// ----------------------------------------------------------------------------
// modbus_request_framer_test
// Self-checking bench for the modbus request framer, rtu and tcp modes.
// ----------------------------------------------------------------------------
// Request beats go in through a valid/ready channel. A scoreboard works out
// the frame bytes that each accepted beat should produce: its own crc-16,
// mbap header, payload count and mode. Every byte that leaves the block is
// checked against the oldest byte still due. A short directed run covers
// all codes but 2 and 4, the field extremes, stray data beats, abandoned
// frames, empty payloads and mode changes inside a frame. Random phases in
// both modes follow, with random idling on either side, one long receiver
// hold-off and a pause between phases until every due byte has left.
// ----------------------------------------------------------------------------
module modbus_request_framer_test;
	import mrf_pkg::*;

	// codes the block must reject, named for readability
	localparam logic [7:0] FC_DIAGNOSTICS = 8'd8;
	localparam logic [7:0] FC_READ_FILE   = 8'd20;
	localparam logic [7:0] FC_WRITE_FILE  = 8'd21;
	localparam logic [7:0] FC_MASK_WRITE  = 8'd22;
	localparam logic [7:0] FC_READ_FIFO   = 8'd24;

	localparam logic [7:0] DATA_CODES [3] = '{FC_WRITE_COILS, FC_WRITE_REGS, FC_RW_REGS};
	localparam logic [7:0] PLAIN_CODES [10] = '{
		FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
		FC_WRITE_COIL, FC_WRITE_REG, FC_READ_EXC_STATUS, FC_COMM_EVENT_CNT,
		FC_COMM_EVENT_LOG, FC_REPORT_ID
	};
	localparam logic [7:0] REJECTED_CODES [5] = '{
		FC_DIAGNOSTICS, FC_READ_FILE, FC_WRITE_FILE, FC_MASK_WRITE, FC_READ_FIFO
	};

	// worst header burst is 17 bytes, so this covers any trailing work
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_OFF_CYCLES = 250;
	localparam int BEATS_PER_PHASE = 32;

	// one request beat as driven onto the input channel
	typedef struct {
		logic        command;
		logic [7:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] quantity;
		logic [15:0] write_start_address;
		logic [15:0] write_quantity;
		logic [7:0]  payload_len;
		logic [15:0] single_value;
		logic [7:0]  unit_id;
		logic [15:0] transaction_id;
		logic [7:0]  data_byte;
	} beat_t;

	// one frame byte as seen on the output channel
	typedef struct packed {
		logic [7:0] value;
		logic       fin;
		logic       err;
	} framer_byte_t;

	// frame builder model plus the queue of bytes still to come out
	class request_frame_board;
		framer_byte_t frame_bytes_due[$];
		bit           tcp;
		bit           open;
		logic [7:0]   remaining;
		logic [15:0]  crc;
		int           beats;
		int           bytes_seen;
		int           error_results;
		int           frames_done;
		int           bad;

		function new();
			tcp = 1'b0;
			open = 1'b0;
			remaining = '0;
			crc = CRC_INIT;
			beats = 0;
			bytes_seen = 0;
			error_results = 0;
			frames_done = 0;
			bad = 0;
		endfunction

		function void set_mode(bit m);
			tcp = m;
		endfunction

		// reflected crc-16, one bit at a time
		function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			logic        lsb;
			r = c ^ {8'h00, b};
			for (int k = 0; k < 8; k++) begin
				lsb = r[0];
				r = r >> 1;
				if (lsb)
					r = r ^ CRC_POLY;
			end
			return r;
		endfunction

		function void emit(logic [7:0] v, logic l, logic e);
			framer_byte_t fb;
			fb.value = v;
			fb.fin = l;
			fb.err = e;
			if (e)
				error_results++;
			frame_bytes_due.push_back(fb);
		endfunction

		// bytes after the mbap header run through the crc while in rtu mode
		function void emit_frame_byte(logic [7:0] v);
			if (!tcp)
				crc = crc_step(crc, v);
			emit(v, 1'b0, 1'b0);
		endfunction

		function void close_frame();
			framer_byte_t tail;
			if (!tcp) begin
				emit(crc[7:0], 1'b0, 1'b0);
				emit(crc[15:8], 1'b0, 1'b0);
			end
			tail = frame_bytes_due.pop_back();
			tail.fin = 1'b1;
			frame_bytes_due.push_back(tail);
			open = 1'b0;
			remaining = '0;
			frames_done++;
		endfunction

		// works out the bytes that one accepted beat releases
		function void note_beat(beat_t b);
			logic [7:0]  pdu [10];
			int          plen;
			bit          carries_data;
			logic [15:0] len;
			beats++;
			if (b.command == CMD_DATA) begin
				// stray data beat leaves the frame state alone
				if (!open || remaining == 0) begin
					emit(BYTE_ZERO, 1'b1, 1'b1);
					return;
				end
				emit_frame_byte(b.data_byte);
				remaining--;
				if (remaining == 0)
					close_frame();
				return;
			end
			// any header drops an unfinished frame
			open = 1'b0;
			remaining = '0;
			crc = CRC_INIT;
			carries_data = 1'b0;
			plen = 0;
			pdu[0] = b.function_code;
			pdu[1] = b.start_address[15:8];
			pdu[2] = b.start_address[7:0];
			pdu[3] = b.quantity[15:8];
			pdu[4] = b.quantity[7:0];
			for (int k = 5; k < 10; k++)
				pdu[k] = BYTE_ZERO;
			case (b.function_code)
			FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT:
				plen = 5;
			FC_WRITE_COIL, FC_WRITE_REG: begin
				pdu[3] = b.single_value[15:8];
				pdu[4] = b.single_value[7:0];
				plen = 5;
			end
			FC_WRITE_COILS, FC_WRITE_REGS: begin
				pdu[5] = b.payload_len;
				plen = 6;
				carries_data = 1'b1;
			end
			FC_RW_REGS: begin
				pdu[5] = b.write_start_address[15:8];
				pdu[6] = b.write_start_address[7:0];
				pdu[7] = b.write_quantity[15:8];
				pdu[8] = b.write_quantity[7:0];
				pdu[9] = b.payload_len;
				plen = 10;
				carries_data = 1'b1;
			end
			FC_READ_EXC_STATUS, FC_COMM_EVENT_CNT, FC_COMM_EVENT_LOG, FC_REPORT_ID:
				plen = 1;
			default: begin
				emit(BYTE_ZERO, 1'b1, 1'b1);
				return;
			end
			endcase
			if (tcp) begin
				len = 16'(plen + (carries_data ? int'(b.payload_len) : 0) + 1);
				emit(b.transaction_id[15:8], 1'b0, 1'b0);
				emit(b.transaction_id[7:0], 1'b0, 1'b0);
				emit(BYTE_ZERO, 1'b0, 1'b0);
				emit(BYTE_ZERO, 1'b0, 1'b0);
				emit(len[15:8], 1'b0, 1'b0);
				emit(len[7:0], 1'b0, 1'b0);
			end
			emit_frame_byte(b.unit_id);
			for (int k = 0; k < plen; k++)
				emit_frame_byte(pdu[k]);
			if (carries_data && b.payload_len != 0) begin
				open = 1'b1;
				remaining = b.payload_len;
				return;
			end
			close_frame();
		endfunction

		function void check_byte(logic [7:0] v, logic l, logic e);
			framer_byte_t want;
			bytes_seen++;
			if (frame_bytes_due.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("byte %0d: nothing due, got %02h last %0b error %0b",
						bytes_seen, v, l, e);
				return;
			end
			want = frame_bytes_due.pop_front();
			if (want.value !== v || want.fin !== l || want.err !== e) begin
				bad++;
				if (bad <= 10)
					$display("byte %0d: expected %02h last %0b error %0b, got %02h last %0b error %0b",
						bytes_seen, want.value, want.fin, want.err, v, l, e);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [7:0]  function_code;
	logic [15:0] start_address;
	logic [15:0] quantity;
	logic [15:0] write_start_address;
	logic [15:0] write_quantity;
	logic [7:0]  payload_len;
	logic [15:0] single_value;
	logic [7:0]  unit_id;
	logic [15:0] transaction_id;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_byte;
	logic        last;
	logic        error;

	request_frame_board board;

	// idling switches, flipped per phase
	bit tx_idle_on;
	bit rx_idle_on;
	// raised by the stimulus, picked up and counted down by the sink
	bit hold_request;
	bit hold_seen;

	modbus_request_framer dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.command             (command),
		.function_code       (function_code),
		.start_address       (start_address),
		.quantity            (quantity),
		.write_start_address (write_start_address),
		.write_quantity      (write_quantity),
		.payload_len         (payload_len),
		.single_value        (single_value),
		.unit_id             (unit_id),
		.transaction_id      (transaction_id),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.frame_byte          (frame_byte),
		.last                (last),
		.error               (error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling, far above the slowest legal run
	initial begin
		#20000000;
		$display("modbus_request_framer_test: errors");
		$finish;
	end

	// mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// payload sizes kept small mostly, the odd long one
	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range(0, 6));
		if (r < 90)
			return 8'($urandom_range(7, 24));
		if (r < 97)
			return 8'($urandom_range(25, 80));
		return 8'($urandom_range(81, 255));
	endfunction

	function automatic bit is_supported(logic [7:0] c);
		foreach (DATA_CODES[k])
			if (DATA_CODES[k] == c)
				return 1'b1;
		foreach (PLAIN_CODES[k])
			if (PLAIN_CODES[k] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [7:0] rejected_code();
		logic [7:0] c;
		if ($urandom_range(0, 1) == 0)
			return REJECTED_CODES[$urandom_range(0, 4)];
		do
			c = 8'($urandom);
		while (is_supported(c));
		return c;
	endfunction

	// header with every field random apart from code and count
	function automatic beat_t make_header(logic [7:0] code, logic [7:0] cnt);
		beat_t b;
		b.command = CMD_HEADER;
		b.function_code = code;
		b.start_address = 16'($urandom);
		b.quantity = 16'($urandom);
		b.write_start_address = 16'($urandom);
		b.write_quantity = 16'($urandom);
		b.payload_len = cnt;
		b.single_value = 16'($urandom);
		b.unit_id = 8'($urandom);
		b.transaction_id = 16'($urandom);
		b.data_byte = 8'($urandom);
		return b;
	endfunction

	// data beat; the header fields carry noise the block should ignore
	function automatic beat_t make_data(logic [7:0] v);
		beat_t b;
		b = make_header(8'($urandom), 8'($urandom));
		b.command = CMD_DATA;
		b.data_byte = v;
		return b;
	endfunction

	// holds valid and payload until the beat is taken, then maybe idles
	task automatic send_beat(input beat_t b);
		int gap;
		in_valid <= 1'b1;
		command <= b.command;
		function_code <= b.function_code;
		start_address <= b.start_address;
		quantity <= b.quantity;
		write_start_address <= b.write_start_address;
		write_quantity <= b.write_quantity;
		payload_len <= b.payload_len;
		single_value <= b.single_value;
		unit_id <= b.unit_id;
		transaction_id <= b.transaction_id;
		data_byte <= b.data_byte;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_beat(b);
		gap = pick_gap(tx_idle_on);
		// valid stays up when the next beat follows straight on
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering beats until every due byte is out and the block is quiet
	task automatic drain_frames();
		in_valid <= 1'b0;
		while (board.frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		board.set_mode(m);
		cfg_we <= 1'b0;
	endtask

	// one random request: mostly well formed frames, some noise
	task automatic random_episode();
		beat_t      b;
		int         r;
		int         n;
		logic [7:0] code;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			if ($urandom_range(0, 99) < 45)
				code = DATA_CODES[$urandom_range(0, 2)];
			else
				code = PLAIN_CODES[$urandom_range(0, 9)];
			b = make_header(code, pick_count());
			send_beat(b);
			if (code == FC_WRITE_COILS || code == FC_WRITE_REGS || code == FC_RW_REGS) begin
				n = b.payload_len;
				// now and then cut the payload short so the next header abandons it
				if (n > 0 && $urandom_range(0, 99) < 12)
					n = $urandom_range(0, n - 1);
				repeat (n) send_beat(make_data(8'($urandom)));
			end
		end else if (r < 82) begin
			send_beat(make_header(rejected_code(), pick_count()));
		end else if (r < 92) begin
			send_beat(make_data(8'($urandom)));
		end else begin
			send_beat(make_header(8'($urandom), pick_count()));
		end
	endtask

	// sink: checks every byte taken, stalls at random, honours the hold-off
	initial begin : sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_byte(frame_byte, last, error);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
				hold_seen = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap(rx_idle_on);
			end
		end
	end

	initial begin : stimulus
		beat_t b;
		int    phase_start;
		board = new();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_request = 1'b0;
		hold_seen = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_HEADER;
		function_code <= '0;
		start_address <= '0;
		quantity <= '0;
		write_start_address <= '0;
		write_quantity <= '0;
		payload_len <= '0;
		single_value <= '0;
		unit_id <= '0;
		transaction_id <= '0;
		data_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// directed, rtu: read with all-ones address then all-zero address
		b = make_header(FC_READ_HOLDING, 8'h00);
		b.start_address = 16'hFFFF;
		b.quantity = 16'h0000;
		b.unit_id = 8'hFF;
		send_beat(b);
		b = make_header(FC_READ_COILS, 8'hFF);
		b.start_address = 16'h0000;
		b.quantity = 16'hFFFF;
		b.unit_id = 8'h00;
		send_beat(b);
		// single writes take the value in place of the quantity
		b = make_header(FC_WRITE_COIL, 8'h00);
		b.single_value = 16'hFF00;
		send_beat(b);
		b = make_header(FC_WRITE_REG, 8'h00);
		b.single_value = 16'h00FF;
		send_beat(b);
		// function-code-only requests
		send_beat(make_header(FC_READ_EXC_STATUS, 8'h00));
		send_beat(make_header(FC_COMM_EVENT_CNT, 8'h00));
		send_beat(make_header(FC_COMM_EVENT_LOG, 8'h00));
		send_beat(make_header(FC_REPORT_ID, 8'h00));
		// multiple writes: one byte, empty payload, read/write with two bytes
		send_beat(make_header(FC_WRITE_COILS, 8'd1));
		send_beat(make_data(8'hFF));
		send_beat(make_header(FC_WRITE_REGS, 8'd0));
		send_beat(make_header(FC_RW_REGS, 8'd2));
		send_beat(make_data(8'h00));
		send_beat(make_data(8'hA5));
		// rejected codes and a stray data beat
		send_beat(make_header(FC_DIAGNOSTICS, 8'd3));
		send_beat(make_header(8'hFF, 8'd3));
		send_beat(make_data(8'h5A));
		// long payload, interrupted by a mode change and then a new header
		send_beat(make_header(FC_WRITE_REGS, 8'd255));
		send_beat(make_data(8'($urandom)));
		drain_frames();
		write_mode(1'b1);
		send_beat(make_data(8'($urandom)));
		// tcp length field above one byte, then abandoned
		send_beat(make_header(FC_RW_REGS, 8'd255));
		send_beat(make_data(8'($urandom)));
		// frame begun in tcp, closed in rtu so a crc of the tail follows
		send_beat(make_header(FC_WRITE_COILS, 8'd2));
		send_beat(make_data(8'($urandom)));
		drain_frames();
		write_mode(1'b0);
		send_beat(make_data(8'($urandom)));

		// random phases, alternating mode and idling pattern
		for (int p = 0; p < 6; p++) begin
			drain_frames();
			write_mode(p % 2 == 0);
			tx_idle_on = (p != 0) && (p != 4);
			rx_idle_on = (p != 0) && (p != 3);
			phase_start = board.beats;
			if (p == 2) begin
				// sink holds off while beats keep coming, so the input backs up
				hold_request = 1'b1;
				tx_idle_on = 1'b0;
				while (board.beats - phase_start < 40)
					random_episode();
				tx_idle_on = 1'b1;
			end
			while (board.beats - phase_start < BEATS_PER_PHASE)
				random_episode();
		end

		drain_frames();
		$display("covered %0d request beats in rtu and tcp modes: %0d frames, %0d error results",
			board.beats, board.frames_done, board.error_results);
		$display("checked %0d frame bytes, long sink hold-off %0s, %0d mismatches",
			board.bytes_seen, hold_seen ? "done" : "missed", board.bad);
		if (board.bad == 0 && board.frame_bytes_due.size() == 0)
			$display("modbus_request_framer_test: clean");
		else
			$display("modbus_request_framer_test: errors");
		$finish;
	end

endmodule
